// ----- sv/ric_pkg.sv -----
package ric_pkg;

  // Major opcodes
  localparam logic [6:0] OPC_LOAD      = 7'h03;
  localparam logic [6:0] OPC_MISC_MEM  = 7'h0F;
  localparam logic [6:0] OPC_OP_IMM    = 7'h13;
  localparam logic [6:0] OPC_AUIPC     = 7'h17;
  localparam logic [6:0] OPC_OP_IMM_32 = 7'h1B;
  localparam logic [6:0] OPC_STORE     = 7'h23;
  localparam logic [6:0] OPC_OP        = 7'h33;
  localparam logic [6:0] OPC_LUI       = 7'h37;
  localparam logic [6:0] OPC_OP_32     = 7'h3B;
  localparam logic [6:0] OPC_BRANCH    = 7'h63;
  localparam logic [6:0] OPC_JALR      = 7'h67;
  localparam logic [6:0] OPC_JAL       = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM    = 7'h73;

  // funct3 codes that matter on their own
  localparam logic [2:0] F3_ADD    = 3'd0;
  localparam logic [2:0] F3_SLL    = 3'd1;
  localparam logic [2:0] F3_SLT    = 3'd2;
  localparam logic [2:0] F3_SLTU   = 3'd3;
  localparam logic [2:0] F3_XOR    = 3'd4;
  localparam logic [2:0] F3_SR     = 3'd5;
  localparam logic [2:0] F3_OR     = 3'd6;
  localparam logic [2:0] F3_LOAD_MAX   = 3'd6;
  localparam logic [2:0] F3_FENCE_MAX  = 3'd1;
  localparam logic [2:0] F3_STORE_MAX  = 3'd3;
  localparam logic [2:0] F3_BEQ_MAX    = 3'd1;
  localparam logic [2:0] F3_BLT_MIN    = 3'd4;
  localparam logic [2:0] F3_PRIV       = 3'd0;
  localparam logic [2:0] F3_CSR_REG_MAX = 3'd3;
  localparam logic [2:0] F3_CSR_IMM_MIN = 3'd5;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_SFENCE = 7'h09;
  localparam logic [5:0] F6_BASE   = 6'h00;
  localparam logic [5:0] F6_ALT    = 6'h10;

  // CSRs whose access changes trap state
  localparam logic [11:0] CSR_MEDELEG = 12'h302;
  localparam logic [11:0] CSR_MIE     = 12'h304;
  localparam logic [11:0] CSR_MTVEC   = 12'h305;
  localparam logic [11:0] CSR_MEPC    = 12'h341;
  localparam logic [11:0] CSR_MCAUSE  = 12'h342;

  // Dense operation numbers
  localparam logic [5:0] OP_LB      = 6'd0;
  localparam logic [5:0] OP_FENCE   = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd9;
  localparam logic [5:0] OP_SLLI    = 6'd10;
  localparam logic [5:0] OP_SLTI    = 6'd11;
  localparam logic [5:0] OP_SLTIU   = 6'd12;
  localparam logic [5:0] OP_XORI    = 6'd13;
  localparam logic [5:0] OP_SRLI    = 6'd14;
  localparam logic [5:0] OP_SRAI    = 6'd15;
  localparam logic [5:0] OP_ORI     = 6'd16;
  localparam logic [5:0] OP_ANDI    = 6'd17;
  localparam logic [5:0] OP_AUIPC   = 6'd18;
  localparam logic [5:0] OP_ADDIW   = 6'd19;
  localparam logic [5:0] OP_SLLIW   = 6'd20;
  localparam logic [5:0] OP_SRLIW   = 6'd21;
  localparam logic [5:0] OP_SRAIW   = 6'd22;
  localparam logic [5:0] OP_SB      = 6'd23;
  localparam logic [5:0] OP_ADD     = 6'd27;
  localparam logic [5:0] OP_LUI     = 6'd37;
  localparam logic [5:0] OP_ADDW    = 6'd38;
  localparam logic [5:0] OP_BEQ     = 6'd48;
  localparam logic [5:0] OP_BLT_BIAS = 6'd46;
  localparam logic [5:0] OP_JALR    = 6'd54;
  localparam logic [5:0] OP_JAL     = 6'd55;
  localparam logic [5:0] OP_SFENCE  = 6'd56;
  localparam logic [5:0] OP_CSR_IMM_BIAS = 6'd55;
  localparam logic [5:0] OP_NONE    = 6'd0;
  localparam logic [5:0] OP_UNKNOWN = 6'd63;

  // Offsets inside an R-type group
  localparam logic [5:0] RT_SUB    = 6'd1;
  localparam logic [5:0] RT_SRL    = 6'd6;
  localparam logic [5:0] RT_SRA    = 6'd7;
  localparam logic [5:0] RT_LOW    = 6'd1;
  localparam logic [5:0] RT_HIGH   = 6'd2;

  typedef struct packed {
    logic [5:0] operation_id;
    logic       decode_fault;
    logic       ends_block;
  } decode_t;

endpackage

// ----- sv/rv64i_instruction_classifier.sv -----
// Channel   Handshake                  Payload
// instr     instr_valid / instr_stall  instruction_word[31:0]
// result    result_valid / result_stall operation_id[5:0], decode_fault, ends_block
//
// One instruction per cycle while result_stall is low; two registers (input register, result register).
// Decode is a single pass of opcode/funct compare logic between the two registers.
// rst is synchronous, active high, and empties both registers.
// A stall on result holds the result register; instr_stall rises only when both stages
// are full and result_stall is high.
module rv64i_instruction_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        instr_valid,
  output logic        instr_stall,
  input  logic [31:0] instruction_word,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [5:0]  operation_id,
  output logic        decode_fault,
  output logic        ends_block
);
  import ric_pkg::*;

  logic        s1_valid;
  logic [31:0] s1_word;
  logic        s1_advance;
  decode_t     dec;

  assign s1_advance  = s1_valid && (!result_valid || !result_stall);
  assign instr_stall = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!instr_stall) begin
      s1_valid <= instr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr_valid && !instr_stall) begin
      s1_word <= instruction_word;
    end
  end

  ric_decode u_decode (
    .word (s1_word),
    .dec  (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= s1_valid;
    end
  end

  // hold the result while stalled
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      operation_id <= dec.operation_id;
      decode_fault <= dec.decode_fault;
      ends_block   <= dec.ends_block;
    end
  end

  a_fault_zero_op: assert property (@(posedge clk) disable iff (rst)
    result_valid && decode_fault |-> operation_id == OP_NONE && ends_block)
    else $error("fault result carries an operation or does not end the block");

  a_unknown_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && operation_id == OP_UNKNOWN |-> ends_block && !decode_fault)
    else $error("unknown opcode result is malformed");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !(result_valid && result_stall) |=> result_valid)
    else $error("decoded transaction lost between stages");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    instr_stall |-> s1_valid && result_valid && result_stall)
    else $error("input stalled without a full pipeline");

endmodule

// ----- sv/ric_decode.sv -----
module ric_decode (
  input  logic [31:0]     word,
  output ric_pkg::decode_t dec
);
  import ric_pkg::*;

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [5:0]  f6;
  logic [11:0] csr;
  logic [5:0]  f3_ext;
  logic [5:0]  op;
  logic [5:0]  rt_base;
  logic        fault;
  logic        unknown;
  logic        flow;
  logic        trap_csr;

  assign opc    = word[6:0];
  assign f3     = word[14:12];
  assign f7     = word[31:25];
  assign f6     = word[31:26];
  assign csr    = word[31:20];
  assign f3_ext = {3'b000, f3};

  assign trap_csr = (csr == CSR_MEDELEG) || (csr == CSR_MIE) || (csr == CSR_MTVEC) ||
                    (csr == CSR_MEPC) || (csr == CSR_MCAUSE);

  always_comb begin
    op      = OP_NONE;
    fault   = 1'b0;
    unknown = 1'b0;
    flow    = 1'b0;
    rt_base = (opc == OPC_OP) ? OP_ADD : OP_ADDW;
    case (opc)
      OPC_LOAD: begin
        if (f3 <= F3_LOAD_MAX) op = OP_LB + f3_ext;
        else fault = 1'b1;
      end
      OPC_MISC_MEM: begin
        if (f3 <= F3_FENCE_MAX) op = OP_FENCE + f3_ext;
        else fault = 1'b1;
      end
      OPC_OP_IMM: begin
        case (f3)
          F3_ADD:  op = OP_ADDI;
          F3_SLL: begin
            if (f6 == F6_BASE) op = OP_SLLI;
            else fault = 1'b1;
          end
          F3_SLT:  op = OP_SLTI;
          F3_SLTU: op = OP_SLTIU;
          F3_XOR:  op = OP_XORI;
          F3_SR: begin
            if (f6 == F6_BASE) op = OP_SRLI;
            else if (f6 == F6_ALT) op = OP_SRAI;
            else fault = 1'b1;
          end
          F3_OR:   op = OP_ORI;
          default: op = OP_ANDI;
        endcase
      end
      OPC_AUIPC: op = OP_AUIPC;
      OPC_OP_IMM_32: begin
        if (f3 == F3_ADD) op = OP_ADDIW;
        else if (f3 == F3_SLL && f7 == F7_BASE) op = OP_SLLIW;
        else if (f3 == F3_SR && f7 == F7_BASE) op = OP_SRLIW;
        else if (f3 == F3_SR && f7 == F7_ALT) op = OP_SRAIW;
        else fault = 1'b1;
      end
      OPC_STORE: begin
        if (f3 <= F3_STORE_MAX) op = OP_SB + f3_ext;
        else fault = 1'b1;
      end
      OPC_OP, OPC_OP_32: begin
        if (f3 == F3_ADD) begin
          if (f7 == F7_BASE) op = rt_base;
          else if (f7 == F7_ALT) op = rt_base + RT_SUB;
          else fault = 1'b1;
        end else if (f3 == F3_SR) begin
          if (f7 == F7_BASE) op = rt_base + RT_SRL;
          else if (f7 == F7_ALT) op = rt_base + RT_SRA;
          else fault = 1'b1;
        end else if (f7 != F7_BASE) begin
          fault = 1'b1;
        end else if (f3 <= F3_XOR) begin
          op = rt_base + RT_LOW + f3_ext;
        end else begin
          op = rt_base + RT_HIGH + f3_ext;
        end
      end
      OPC_LUI: op = OP_LUI;
      OPC_BRANCH: begin
        flow = 1'b1;
        if (f3 <= F3_BEQ_MAX) op = OP_BEQ + f3_ext;
        else if (f3 >= F3_BLT_MIN) op = OP_BLT_BIAS + f3_ext;
        else fault = 1'b1;
      end
      OPC_JALR: begin
        flow = 1'b1;
        if (f3 == F3_ADD) op = OP_JALR;
        else fault = 1'b1;
      end
      OPC_JAL: begin
        flow = 1'b1;
        op   = OP_JAL;
      end
      OPC_SYSTEM: begin
        flow = (f3 == F3_PRIV) || trap_csr;
        // only sfence.vma is legal among the privileged forms
        if (f3 == F3_PRIV) begin
          if (f7 == F7_SFENCE) op = OP_SFENCE;
          else fault = 1'b1;
        end else if (f3 <= F3_CSR_REG_MAX) begin
          op = OP_SFENCE + f3_ext;
        end else if (f3 >= F3_CSR_IMM_MIN) begin
          op = OP_CSR_IMM_BIAS + f3_ext;
        end else begin
          fault = 1'b1;
        end
      end
      default: begin
        unknown = 1'b1;
        op      = OP_UNKNOWN;
      end
    endcase
  end

  assign dec.operation_id = fault ? OP_NONE : op;
  assign dec.decode_fault = fault;
  assign dec.ends_block   = fault || unknown || flow;

endmodule

// ----- tb/rv64i_instruction_classifier_tb.sv -----
`timescale 1ns / 100ps

module rv64i_instruction_classifier_tb;
  import ric_pkg::*;

  localparam int RANDOM_COUNT = 1850;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        instr_valid;
  logic        instr_stall;
  logic [31:0] instruction_word;
  logic        result_valid;
  logic        result_stall;
  logic [5:0]  operation_id;
  logic        decode_fault;
  logic        ends_block;

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  quiet_phase = 1'b0;

  rv64i_instruction_classifier dut (
    .clk              (clk),
    .rst              (rst),
    .instr_valid      (instr_valid),
    .instr_stall      (instr_stall),
    .instruction_word (instruction_word),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .operation_id     (operation_id),
    .decode_fault     (decode_fault),
    .ends_block       (ends_block)
  );

  class decode_scoreboard;
    decode_t expected_decodes[$];

    function automatic decode_t predict_decode(logic [31:0] w);
      logic [6:0]  opc;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [5:0]  f6;
      logic [11:0] csr;
      logic [5:0]  op;
      logic [5:0]  rt_base;
      bit          legal;
      bit          known;
      decode_t     d;
      opc = w[6:0];
      f3 = w[14:12];
      f7 = w[31:25];
      f6 = w[31:26];
      csr = w[31:20];
      op = OP_NONE;
      legal = 1'b1;
      known = 1'b1;
      case (opc)
        OPC_LOAD: begin
          if (f3 <= F3_LOAD_MAX) op = OP_LB + 6'(f3);
          else legal = 1'b0;
        end
        OPC_MISC_MEM: begin
          if (f3 <= F3_FENCE_MAX) op = OP_FENCE + 6'(f3);
          else legal = 1'b0;
        end
        OPC_OP_IMM: begin
          case (f3)
            F3_ADD:  op = OP_ADDI;
            F3_SLL: begin
              if (f6 == F6_BASE) op = OP_SLLI;
              else legal = 1'b0;
            end
            F3_SLT:  op = OP_SLTI;
            F3_SLTU: op = OP_SLTIU;
            F3_XOR:  op = OP_XORI;
            F3_SR: begin
              if (f6 == F6_BASE) op = OP_SRLI;
              else if (f6 == F6_ALT) op = OP_SRAI;
              else legal = 1'b0;
            end
            F3_OR:   op = OP_ORI;
            default: op = OP_ANDI;
          endcase
        end
        OPC_AUIPC: op = OP_AUIPC;
        OPC_OP_IMM_32: begin
          if (f3 == F3_ADD) op = OP_ADDIW;
          else if (f3 == F3_SLL && f7 == F7_BASE) op = OP_SLLIW;
          else if (f3 == F3_SR && f7 == F7_BASE) op = OP_SRLIW;
          else if (f3 == F3_SR && f7 == F7_ALT) op = OP_SRAIW;
          else legal = 1'b0;
        end
        OPC_STORE: begin
          if (f3 <= F3_STORE_MAX) op = OP_SB + 6'(f3);
          else legal = 1'b0;
        end
        OPC_OP, OPC_OP_32: begin
          rt_base = (opc == OPC_OP) ? OP_ADD : OP_ADDW;
          if (f3 == F3_ADD) begin
            if (f7 == F7_BASE) op = rt_base;
            else if (f7 == F7_ALT) op = rt_base + RT_SUB;
            else legal = 1'b0;
          end else if (f3 == F3_SR) begin
            if (f7 == F7_BASE) op = rt_base + RT_SRL;
            else if (f7 == F7_ALT) op = rt_base + RT_SRA;
            else legal = 1'b0;
          end else if (f7 != F7_BASE) begin
            legal = 1'b0;
          end else if (f3 <= F3_XOR) begin
            op = rt_base + RT_LOW + 6'(f3);
          end else begin
            op = rt_base + RT_HIGH + 6'(f3);
          end
        end
        OPC_LUI: op = OP_LUI;
        OPC_BRANCH: begin
          if (f3 <= F3_BEQ_MAX) op = OP_BEQ + 6'(f3);
          else if (f3 >= F3_BLT_MIN) op = OP_BLT_BIAS + 6'(f3);
          else legal = 1'b0;
        end
        OPC_JALR: begin
          if (f3 == F3_ADD) op = OP_JALR;
          else legal = 1'b0;
        end
        OPC_JAL: op = OP_JAL;
        OPC_SYSTEM: begin
          if (f3 == F3_PRIV) begin
            // only sfence.vma passes; ecall, ebreak and mret trap as faults
            if (f7 == F7_SFENCE) op = OP_SFENCE;
            else legal = 1'b0;
          end else if (f3 <= F3_CSR_REG_MAX) begin
            op = OP_SFENCE + 6'(f3);
          end else if (f3 >= F3_CSR_IMM_MIN) begin
            op = OP_CSR_IMM_BIAS + 6'(f3);
          end else begin
            legal = 1'b0;
          end
        end
        default: known = 1'b0;
      endcase

      d.operation_id = known ? op : OP_UNKNOWN;
      d.decode_fault = !legal;
      if (!legal) d.operation_id = OP_NONE;
      d.ends_block = !legal || !known || opc == OPC_BRANCH || opc == OPC_JALR ||
                     opc == OPC_JAL;
      if (legal && opc == OPC_SYSTEM &&
          (f3 == F3_PRIV || csr == CSR_MEDELEG || csr == CSR_MIE ||
           csr == CSR_MTVEC || csr == CSR_MEPC || csr == CSR_MCAUSE))
        d.ends_block = 1'b1;
      return d;
    endfunction

    function void note_instruction(logic [31:0] w);
      expected_decodes.insert(expected_decodes.size(), predict_decode(w));
    endfunction

    function int check_result(logic [5:0] op, logic fault, logic ends);
      decode_t exp_d;
      int      errs;
      errs = 0;
      if (expected_decodes.size() == 0) begin
        $display("%0t: result with nothing pending: operation_id %0d",
                 $time, op, " decode_fault %0b ends_block %0b", fault, ends);
        return 1;
      end
      exp_d = expected_decodes.pop_front();
      if (op !== exp_d.operation_id) begin
        $display("%0t: operation_id expected %0d actual %0d",
                 $time, exp_d.operation_id, op);
        errs++;
      end
      if (fault !== exp_d.decode_fault) begin
        $display("%0t: decode_fault expected %0b actual %0b",
                 $time, exp_d.decode_fault, fault);
        errs++;
      end
      if (ends !== exp_d.ends_block) begin
        $display("%0t: ends_block expected %0b actual %0b",
                 $time, exp_d.ends_block, ends);
        errs++;
      end
      return errs;
    endfunction

    function int pending();
      return expected_decodes.size();
    endfunction
  endclass

  decode_scoreboard sb = new;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_idle_cycles();
    if (quiet_phase || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [31:0] encode(logic [6:0] f7, logic [2:0] f3, logic [6:0] opc);
    logic [31:0] w;
    w = $urandom;
    w[31:25] = f7;
    w[14:12] = f3;
    w[6:0] = opc;
    return w;
  endfunction

  function automatic logic [31:0] encode_csr(logic [11:0] csr, logic [2:0] f3);
    logic [31:0] w;
    w = encode(7'($urandom), f3, OPC_SYSTEM);
    w[31:20] = csr;
    return w;
  endfunction

  function automatic logic [6:0] pick_known_opcode();
    case ($urandom_range(0, 12))
      0:  return OPC_LOAD;
      1:  return OPC_MISC_MEM;
      2:  return OPC_OP_IMM;
      3:  return OPC_AUIPC;
      4:  return OPC_OP_IMM_32;
      5:  return OPC_STORE;
      6:  return OPC_OP;
      7:  return OPC_LUI;
      8:  return OPC_OP_32;
      9:  return OPC_BRANCH;
      10: return OPC_JALR;
      11: return OPC_JAL;
      default: return OPC_SYSTEM;
    endcase
  endfunction

  function automatic logic [11:0] pick_trap_csr();
    case ($urandom_range(0, 4))
      0: return CSR_MEDELEG;
      1: return CSR_MIE;
      2: return CSR_MTVEC;
      3: return CSR_MEPC;
      default: return CSR_MCAUSE;
    endcase
  endfunction

  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    logic [6:0]  f7;
    int          roll;
    w = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 8) return w;
    if (roll < 18) begin
      w[6:0] = 7'($urandom);
      return w;
    end
    roll = $urandom_range(0, 19);
    if (roll < 8) f7 = F7_BASE;
    else if (roll < 13) f7 = F7_ALT;
    else if (roll < 15) f7 = F7_SFENCE;
    // shift amount bit 5 set on a legal 64-bit shift
    else if (roll < 16) f7 = {F6_BASE, 1'b1};
    else if (roll < 17) f7 = {F6_ALT, 1'b1};
    else f7 = 7'($urandom);
    w = encode(f7, 3'($urandom), pick_known_opcode());
    if (w[6:0] == OPC_SYSTEM && $urandom_range(0, 2) == 0)
      w[31:20] = pick_trap_csr();
    return w;
  endfunction

  task automatic send_instruction(logic [31:0] w);
    int gap;
    gap = pick_idle_cycles();
    if (gap > 0) begin
      instr_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_valid <= 1'b1;
    instruction_word <= w;
    do @(posedge clk); while (instr_stall);
  endtask

  task automatic run_directed();
    send_instruction(32'h0000_0000);
    send_instruction(32'hFFFF_FFFF);
    send_instruction(encode(7'($urandom), 3'd7, OPC_LOAD));
    send_instruction(encode(7'($urandom), F3_SLL, OPC_MISC_MEM));
    send_instruction(encode(7'($urandom), F3_SLT, OPC_MISC_MEM));
    send_instruction(encode({F6_BASE, 1'b1}, F3_SLL, OPC_OP_IMM));
    send_instruction(encode({F6_ALT, 1'b1}, F3_SR, OPC_OP_IMM));
    send_instruction(encode(F7_ALT, F3_SR, OPC_OP_IMM));
    send_instruction(encode({F6_BASE, 1'b1}, F3_SLL, OPC_OP_IMM_32));
    send_instruction(encode(F7_ALT, F3_SR, OPC_OP_IMM_32));
    send_instruction(encode(F7_BASE, F3_SLT, OPC_OP_IMM_32));
    send_instruction(encode(7'($urandom), F3_XOR, OPC_STORE));
    send_instruction(encode(F7_ALT, F3_ADD, OPC_OP));
    send_instruction(encode(F7_ALT, F3_SR, OPC_OP));
    send_instruction(encode(F7_SFENCE, F3_XOR, OPC_OP));
    send_instruction(encode(F7_ALT, F3_ADD, OPC_OP_32));
    send_instruction(encode(F7_BASE, 3'd7, OPC_OP_32));
    send_instruction(encode(7'($urandom), F3_SLT, OPC_BRANCH));
    send_instruction(encode(7'($urandom), 3'd7, OPC_BRANCH));
    send_instruction(encode(7'($urandom), F3_SLL, OPC_JALR));
    send_instruction(encode(7'($urandom), 3'($urandom), OPC_JAL));
    send_instruction(encode(F7_BASE, F3_PRIV, OPC_SYSTEM));
    send_instruction(encode(F7_SFENCE, F3_PRIV, OPC_SYSTEM));
    send_instruction(encode_csr(CSR_MTVEC, F3_SLL));
    send_instruction(encode_csr(CSR_MCAUSE, 3'd7));
    send_instruction(encode_csr(12'h300, F3_SLTU));
    send_instruction(encode_csr(CSR_MEPC, F3_XOR));
  endtask

  // accept, predict and check on the same edge the block sees
  always @(posedge clk) begin
    if (!rst) begin
      if (instr_valid && !instr_stall) sb.note_instruction(instruction_word);
      if (result_valid && !result_stall)
        mismatches += sb.check_result(operation_id, decode_fault, ends_block);
      if ((instr_valid && !instr_stall) || (result_valid && !result_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("rv64i_instruction_classifier_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int gap;
    result_stall <= 1'b0;
    forever begin
      gap = pick_idle_cycles();
      if (gap > 0) begin
        result_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        result_stall <= 1'b0;
      end
      do @(posedge clk); while (!(result_valid && !result_stall));
    end
  end

  initial begin
    rst <= 1'b1;
    instr_valid <= 1'b0;
    instruction_word <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (rst);

    run_directed();
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      // switch between bursts with no idling and idling on both sides
      if (i % 100 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
      send_instruction(random_instruction());
    end
    instr_valid <= 1'b0;

    // let the monitor note the last transaction before draining
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && sb.pending() == 0)
      $display("rv64i_instruction_classifier_tb: done, clean");
    else
      $display("rv64i_instruction_classifier_tb: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ric_pkg.sv
sv/ric_decode.sv
sv/rv64i_instruction_classifier.sv
tb/rv64i_instruction_classifier_tb.sv
